// ===== rtl/fp8c_pkg.sv =====
// Shared types and constants for the FP8 <-> FP32 converter.
package fp8c_pkg;

    // Operation codes carried on the kind field
    typedef enum logic [1:0] {
        KIND_DEC_E4M3 = 2'd0,
        KIND_DEC_E5M2 = 2'd1,
        KIND_ENC_E4M3 = 2'd2,
        KIND_ENC_E5M2 = 2'd3
    } kind_t;

    // FP32 special patterns
    localparam logic [31:0] FP32_QNAN = 32'h7fc0_0000;
    localparam logic [31:0] FP32_INF  = 32'h7f80_0000;

    // FP8 canonical quiet NaN codes
    localparam logic [7:0] E4M3_QNAN = 8'h7c;
    localparam logic [7:0] E5M2_QNAN = 8'h7e;

    // Smallest code that is infinity (emax << mbits), without sign
    localparam logic [11:0] E4M3_INF_MAG = 12'd120;
    localparam logic [11:0] E5M2_INF_MAG = 12'd124;

endpackage

// ===== rtl/fp8c_decode.sv =====
// FP8 (E4M3 or E5M2) byte to FP32 bit pattern.
module fp8c_decode
(
    input  logic        is_e5m2,
    input  logic [7:0]  fp8,
    output logic [31:0] value
);

    logic       sign;
    logic [4:0] exp8;
    logic [2:0] man3;
    logic       exp_max;
    logic [1:0] lead;
    logic [2:0] sub_man;
    logic [7:0] sub_exp;
    logic [7:0] norm_exp;

    // Unpack fields; E5M2 mantissa is left aligned into three bits
    always_comb
    begin
        sign = fp8[7];
        if (is_e5m2)
        begin
            exp8    = fp8[6:2];
            man3    = {fp8[1:0], 1'b0};
            exp_max = (fp8[6:2] == 5'h1f);
        end
        else
        begin
            exp8    = {1'b0, fp8[6:3]};
            man3    = fp8[2:0];
            exp_max = (fp8[6:3] == 4'hf);
        end
    end

    // Normalize a subnormal: find the leading one, drop it, shift the rest up
    always_comb
    begin
        if (man3[2])
            lead = 2'd2;
        else if (man3[1])
            lead = 2'd1;
        else
            lead = 2'd0;

        case (lead)
            2'd2:    sub_man = {man3[1:0], 1'b0};
            2'd1:    sub_man = {man3[0], 2'b00};
            default: sub_man = 3'b000;
        endcase

        sub_exp  = {6'd0, lead} + (is_e5m2 ? 8'd110 : 8'd118);
        norm_exp = {3'd0, exp8} + (is_e5m2 ? 8'd112 : 8'd120);
    end

    // Pick the result class
    always_comb
    begin
        if (exp_max)
        begin
            if (man3 != 3'd0)
                value = fp8c_pkg::FP32_QNAN;
            else
                value = {sign, 31'd0} | fp8c_pkg::FP32_INF;
        end
        else if (exp8 == 5'd0)
        begin
            if (man3 == 3'd0)
                value = {sign, 31'd0};
            else
                value = {sign, sub_exp, sub_man, 20'd0};
        end
        else
        begin
            value = {sign, norm_exp, man3, 20'd0};
        end
    end

endmodule

// ===== rtl/fp8c_encode.sv =====
// FP32 bit pattern to FP8 (E4M3 or E5M2) byte, round to nearest even.
module fp8c_encode
(
    input  logic        is_e5m2,
    input  logic [31:0] fp32,
    output logic [7:0]  fp8
);

    logic              sign;
    logic [7:0]        exp32;
    logic [22:0]       frac;
    logic [25:0]       sig;
    logic signed [9:0] biased;
    logic signed [9:0] sub_shift;
    logic              is_sub;
    logic              too_small;
    logic [4:0]        shamt;
    logic [25:0]       shifted;
    logic [25:0]       below_mask;
    logic              guard;
    logic              sticky;
    logic [11:0]       code_base;
    logic [11:0]       code_rnd;
    logic [11:0]       inf_mag;
    logic [7:0]        inf_code;

    // Unpack and rebias
    always_comb
    begin
        sign   = fp32[31];
        exp32  = fp32[30:23];
        frac   = fp32[22:0];
        sig    = {3'b001, frac};
        biased = $signed({2'b00, exp32}) - (is_e5m2 ? 10'sd112 : 10'sd120);
        is_sub = (biased <= 10'sd0);
        too_small = is_e5m2 ? (biased < -10'sd3) : (biased < -10'sd4);
        inf_mag  = is_e5m2 ? fp8c_pkg::E5M2_INF_MAG : fp8c_pkg::E4M3_INF_MAG;
        inf_code = {sign, inf_mag[6:0]};
    end

    // Alignment shift: 20 or 21 for normals, up to 25 for subnormals
    always_comb
    begin
        sub_shift = (is_e5m2 ? 10'sd22 : 10'sd21) - biased;
        if (is_sub)
            shamt = sub_shift[4:0];
        else
            shamt = is_e5m2 ? 5'd21 : 5'd20;
        shifted    = sig >> shamt;
        below_mask = ~(26'h3ff_ffff << (shamt - 5'd1));
        guard      = sig[shamt - 5'd1];
        sticky     = (sig & below_mask) != 26'd0;
    end

    // Truncated code, then round to nearest even
    always_comb
    begin
        if (is_sub)
            code_base = {8'd0, shifted[3:0]};
        else if (is_e5m2)
            code_base = {2'b00, biased[7:0], shifted[1:0]};
        else
            code_base = {1'b0, biased[7:0], shifted[2:0]};
        code_rnd = code_base + {11'd0, guard & (sticky | code_base[0])};
    end

    // Specials, underflow and overflow
    always_comb
    begin
        if (exp32 == 8'hff)
        begin
            if (frac != 23'd0)
                fp8 = is_e5m2 ? fp8c_pkg::E5M2_QNAN : fp8c_pkg::E4M3_QNAN;
            else
                fp8 = inf_code;
        end
        else if (exp32 == 8'd0)
            fp8 = {sign, 7'd0};
        else if (is_sub && too_small)
            fp8 = {sign, 7'd0};
        else if (code_rnd >= inf_mag)
            fp8 = inf_code;
        else
            fp8 = {sign, code_rnd[6:0]};
    end

endmodule

// ===== rtl/fp8_fp32_converter.sv =====
// FP8 <-> FP32 converter top level: input register, conversion, result register.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------
//   in      | in_valid / in_ready  | kind, operand
//   out     | out_valid / out_ready| result
//
// One item per cycle sustained while out_ready stays high; an accepted item is
// held in the input register, then captured by the result register, and only
// from there can its result transfer take place.
// The input register moves on whenever the result register is empty or is
// being taken, so in_ready drops only when both stages hold items and
// out_ready is low. Reset clears both valid flags; payloads are not reset.
module fp8_fp32_converter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [31:0] operand,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] result
);

    logic                s1_valid_reg;
    fp8c_pkg::kind_t     s1_kind_reg;
    logic [31:0]         s1_operand_reg;
    logic                out_valid_reg;
    logic [31:0]         result_reg;
    logic [31:0]         result_next;
    logic                s1_advance;
    logic                in_xfer;
    logic                is_e5m2;
    logic [31:0]         dec_value;
    logic [7:0]          enc_code;

    // Stage handshakes
    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_xfer    = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_kind_reg    <= fp8c_pkg::kind_t'(kind);
            s1_operand_reg <= operand;
        end
    end

    // Conversion datapath
    assign is_e5m2 = (s1_kind_reg == fp8c_pkg::KIND_DEC_E5M2) ||
                     (s1_kind_reg == fp8c_pkg::KIND_ENC_E5M2);

    fp8c_decode u_decode
    (
        .is_e5m2 (is_e5m2),
        .fp8     (s1_operand_reg[7:0]),
        .value   (dec_value)
    );

    fp8c_encode u_encode
    (
        .is_e5m2 (is_e5m2),
        .fp32    (s1_operand_reg),
        .fp8     (enc_code)
    );

    always_comb
    begin
        unique case (s1_kind_reg)
            fp8c_pkg::KIND_DEC_E4M3,
            fp8c_pkg::KIND_DEC_E5M2: result_next = dec_value;
            default:                 result_next = {24'd0, enc_code};
        endcase
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // A full input stage with room downstream lands in the result register
    a_s1_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance) |=> out_valid_reg)
        else $error("input stage item did not reach result register");

    // Backpressure only when both stages are occupied and the output stalls
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("in_ready low without a full pipeline");

    // Encodes leave the upper 24 bits clear
    a_enc_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_advance &&
         (s1_kind_reg == fp8c_pkg::KIND_ENC_E4M3 ||
          s1_kind_reg == fp8c_pkg::KIND_ENC_E5M2))
        |=> (result_reg[31:8] == 24'd0))
        else $error("encode result has nonzero upper bits");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the FP8 <-> FP32 converter: directed corner cases, then random.
module tb;

    // One accepted conversion and the result it must produce
    typedef struct {
        fp8c_pkg::kind_t op_kind;
        logic [31:0]     op_bits;
        logic [31:0]     want;
    } conversion_t;

    // Predicts each conversion and checks results in transfer order
    class fp8_result_tracker;
        conversion_t pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // FP8 byte to FP32 pattern; subnormals come out as FP32 normals
        function logic [31:0] decode_fp8(logic [7:0] code, int ebits, int mbits, int bias);
            logic [31:0] sign_bit;
            int          emax;
            int          ef;
            int          man;
            int          msb;
            int          e32;
            sign_bit = {code[7], 31'b0};
            emax     = (1 << ebits) - 1;
            ef       = (code >> mbits) & emax;
            man      = code & ((1 << mbits) - 1);
            if (ef == emax)
                return (man != 0) ? fp8c_pkg::FP32_QNAN : (sign_bit | fp8c_pkg::FP32_INF);
            if (ef == 0)
            begin
                if (man == 0)
                    return sign_bit;
                msb = 0;
                for (int i = 0; i < mbits; i++)
                    if (man[i])
                        msb = i;
                e32 = msb + 1 - bias - mbits + 127;
                return sign_bit | (32'(e32) << 23) | (32'(man - (1 << msb)) << (23 - msb));
            end
            return sign_bit | (32'(ef - bias + 127) << 23) | (32'(man) << (23 - mbits));
        endfunction

        // FP32 pattern to FP8 byte, round to nearest even
        function logic [31:0] encode_fp8(logic [31:0] a, int ebits, int mbits, int bias,
                                         logic [7:0] nan_code);
            logic [31:0] sign_byte;
            int unsigned ef;
            int unsigned frac;
            int unsigned sig;
            int unsigned code;
            int unsigned emax;
            int unsigned inf_code;
            int          biased;
            int          shift;
            bit          guard;
            bit          sticky;
            sign_byte = {24'b0, a[31], 7'b0};
            ef        = 32'(a[30:23]);
            frac      = 32'(a[22:0]);
            emax      = (1 << ebits) - 1;
            inf_code  = sign_byte | (emax << mbits);
            if (ef == 255)
                return (frac != 0) ? {24'b0, nan_code} : inf_code;
            if (ef == 0)
                return sign_byte;
            sig    = frac | 32'h0080_0000;
            biased = int'(ef) - 127 + bias;
            if (biased >= 1)
            begin
                shift = 23 - mbits;
                code  = (biased << mbits) + (sig >> shift) - (1 << mbits);
            end
            else
            begin
                // subnormal target: everything past the grid is lost
                shift = 24 - mbits - biased;
                if (shift > 25)
                    return sign_byte;
                code = sig >> shift;
            end
            guard  = sig[shift - 1];
            sticky = (sig & ((1 << (shift - 1)) - 1)) != 0;
            if (guard && (sticky || code[0]))
                code++;
            if (code >= (emax << mbits))
                return inf_code;
            return sign_byte | code;
        endfunction

        function void note_input(fp8c_pkg::kind_t k, logic [31:0] op);
            conversion_t c;
            c.op_kind = k;
            c.op_bits = op;
            case (k)
                fp8c_pkg::KIND_DEC_E4M3: c.want = decode_fp8(op[7:0], 4, 3, 7);
                fp8c_pkg::KIND_DEC_E5M2: c.want = decode_fp8(op[7:0], 5, 2, 15);
                fp8c_pkg::KIND_ENC_E4M3: c.want = encode_fp8(op, 4, 3, 7, fp8c_pkg::E4M3_QNAN);
                default:                 c.want = encode_fp8(op, 5, 2, 15, fp8c_pkg::E5M2_QNAN);
            endcase
            pending.push_back(c);
        endfunction

        function void check_result(logic [31:0] got);
            conversion_t c;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            c = pending.pop_front();
            if (got !== c.want)
            begin
                $display("%0t: mismatch %s operand %h: expected %h, actual %h",
                         $time, c.op_kind.name(), c.op_bits, c.want, got);
                errors++;
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    logic            in_ready;
    fp8c_pkg::kind_t kind      = fp8c_pkg::KIND_DEC_E4M3;
    logic [31:0]     operand   = 32'b0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [31:0]     result;

    int in_idle_pct  = 25;
    int out_idle_pct = 25;

    fp8_result_tracker tracker = new();

    fp8_fp32_converter dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .operand   (operand),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    always #10 clk = ~clk;

    // Receiver stalls at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Observe transfers on both channels
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tracker.note_input(kind, operand);
            if (out_valid && out_ready)
                tracker.check_result(result);
        end
    end

    // Present one item from a falling edge and hold it until transferred
    task automatic send_conversion(fp8c_pkg::kind_t k, logic [31:0] op);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        operand  <= op;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Random items, encodes steered toward the FP8 range, ties and specials
    task automatic run_random(int count);
        fp8c_pkg::kind_t k;
        logic [31:0]     op;
        logic [7:0]      ef;
        logic [22:0]     frac;
        int              lowz;
        for (int n = 0; n < count; n++)
        begin
            k  = fp8c_pkg::kind_t'($urandom_range(3));
            op = $urandom;
            if (k == fp8c_pkg::KIND_ENC_E4M3 || k == fp8c_pkg::KIND_ENC_E5M2)
            begin
                case ($urandom_range(9))
                    0:       ef = op[30:23];
                    1:       ef = $urandom_range(1) ? 8'hff : 8'h00;
                    default: ef = 8'($urandom_range(150, 100));
                endcase
                lowz = $urandom_range(22, 1);
                case ($urandom_range(3))
                    0:       frac = op[22:0];
                    1:       frac = 23'($urandom & ~((1 << lowz) - 1));
                    2:       frac = 23'(($urandom & ~((1 << lowz) - 1)) | (1 << (lowz - 1)));
                    default: frac = $urandom_range(1) ? 23'h7fffff : 23'h0;
                endcase
                op = {op[31], ef, frac};
            end
            send_conversion(k, op);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // E4M3 decodes: zeros, subnormals, normals, infinities, NaNs
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'hdead_be00);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h0000_0080);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'hffff_ff01);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h0000_0087);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h1234_5608);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h0000_0077);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h0000_0078);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h0000_00f8);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h0000_0079);
        send_conversion(fp8c_pkg::KIND_DEC_E4M3, 32'h0000_00ff);
        // E5M2 decodes
        send_conversion(fp8c_pkg::KIND_DEC_E5M2, 32'h0000_0003);
        send_conversion(fp8c_pkg::KIND_DEC_E5M2, 32'hffff_ff7b);
        send_conversion(fp8c_pkg::KIND_DEC_E5M2, 32'h0000_00fc);
        send_conversion(fp8c_pkg::KIND_DEC_E5M2, 32'h0000_00fd);
        // E4M3 encodes: NaN, infinity, zero, FP32 subnormal, tie, overflow by rounding,
        // exactly half the smallest subnormal, just above it, carry into normal
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h7fc0_0001);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'hff80_0000);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h8000_0000);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h0000_0001);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h3f88_0000);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h4378_0000);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h3a80_0000);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h3a80_0001);
        send_conversion(fp8c_pkg::KIND_ENC_E4M3, 32'h3c7f_ffff);
        // E5M2 encodes: negative NaN, infinity, tiny negative, tie past the largest finite
        send_conversion(fp8c_pkg::KIND_ENC_E5M2, 32'hffc0_0000);
        send_conversion(fp8c_pkg::KIND_ENC_E5M2, 32'h7f80_0000);
        send_conversion(fp8c_pkg::KIND_ENC_E5M2, 32'hb700_0001);
        send_conversion(fp8c_pkg::KIND_ENC_E5M2, 32'h4770_0000);
        wait_for_results();

        run_random(600);

        // back-to-back stretch with no idling on either side
        in_idle_pct  = 0;
        out_idle_pct = 0;
        run_random(400);
        wait_for_results();

        in_idle_pct  = 25;
        out_idle_pct = 25;
        run_random(650);
        wait_for_results();

        repeat (10) @(negedge clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("[fp8_fp32_converter] OK");
        else
            $display("[fp8_fp32_converter] ERROR");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("[fp8_fp32_converter] ERROR");
        $finish;
    end

endmodule
